FILE: hdl/sse_pkg.sv
// Shared constants and types of the summary statistics engine.
// Depends on nothing; the engine and the testbench use it by scoped names.
package sse_pkg;

   // Largest number of samples that one data set accumulates.
   localparam int MaxSamples = 65536;
   // Significant bits of an incoming sample, sign-extended from the top one.
   localparam int SampleBits = 24;
   // Reset value of the band multiplier, Q8.8 (about 2.33).
   localparam logic [15:0] ZFactorReset = 16'd596;

   // Sequencer states: sample intake, then the shared unit's closing phases.
   typedef enum logic [3:0] {
      ST_IDLE,   // waiting for a sample
      ST_SQR,    // add the sample's square to the sum of squares
      ST_MNN,    // count times count (divisor of the variance)
      ST_MNS,    // count times sum of squares
      ST_MSS,    // minus sum times sum
      ST_DVAR,   // variance division
      ST_QSD,    // square root for the standard deviation
      ST_DSE,    // scaled variance over count
      ST_QSE,    // square root for the standard error
      ST_MZ,     // z factor times standard deviation
      ST_DMEAN,  // mean division
      ST_FIN     // band clamp and result load
   } state_type;

endpackage

FILE: hdl/sse_channels.sv
// Valid/ready channel interfaces of the summary statistics engine: sample
// input, result output and the z factor register write. Depends on nothing.
interface sse_req_if;
   logic               valid;
   logic               ready;
   logic signed [23:0] sample;
   logic               last;
   modport source (output valid, sample, last, input ready);
   modport sink (input valid, sample, last, output ready);
endinterface

interface sse_rsp_if;
   logic               valid;
   logic               ready;
   logic [16:0]        count;
   logic signed [39:0] total;
   logic signed [31:0] mean;
   logic signed [23:0] minimum;
   logic signed [23:0] maximum;
   logic [46:0]        variance;
   logic [27:0]        std_dev;
   logic [27:0]        std_err;
   logic signed [31:0] band_low;
   logic signed [31:0] band_high;
   logic               overflowed;
   modport source (output valid, count, total, mean, minimum, maximum, variance,
                   std_dev, std_err, band_low, band_high, overflowed, input ready);
   modport sink (input valid, count, total, mean, minimum, maximum, variance,
                 std_dev, std_err, band_low, band_high, overflowed, output ready);
endinterface

interface sse_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: hdl/summary_statistics_engine.sv
// Summary statistics engine: population mean, variance, standard deviation,
// standard error and a z band over a run of Q20.4 samples closed by last.
// A sample that does not close a set passes through intake, then has its
// square added by the one 24x24 multiplier. The closing sample then runs a
// sequencer over one shared 80-bit add/subtract unit, one bit or one root digit
// a cycle: count squared, count times sum of squares, minus sum squared,
// variance division, square root, scaled variance over count, square root,
// z times deviation, mean division, and last the band clamp and result load.
// The result sits in an output register, so intake of the next set starts
// while it waits.
// The z factor register is always ready and should only be written while idle.
// Depends on sse_pkg and the channel interfaces in sse_channels.sv.
module summary_statistics_engine (
   input  logic       clock,
   input  logic       reset,
   sse_req_if.sink    req_if,
   sse_rsp_if.source  rsp_if,
   sse_csr_if.sink    csr_if
);

   sse_pkg::state_type state_ff, state_in;

   // Accumulators and configuration.
   logic [15:0]        z_ff;
   logic [16:0]        nsmp_ff;
   logic signed [23:0] min_ff;
   logic signed [23:0] max_ff;
   logic signed [39:0] sum_ff;
   logic [62:0]        ssum_ff;
   logic               drop_ff;
   logic [23:0]        mag_ff;
   logic               last_ff;

   // Shared unit working registers.
   logic [79:0] acc_ff;
   logic [79:0] opa_ff;
   logic [63:0] opb_ff;
   logic [33:0] rem_ff;
   logic [27:0] root_ff;
   logic [6:0]  itr_ff;
   logic [32:0] dsr_ff;
   logic [46:0] var_ff;
   logic [27:0] sd_ff;
   logic [27:0] se_ff;
   logic [35:0] zd_ff;
   logic signed [31:0] mean_ff;
   logic        rsp_valid_ff;

   logic signed [23:0] smp;
   logic [23:0]        smp_mag;
   logic [39:0]        sum_mag;
   logic               req_xfer;
   logic               fin_load;
   logic [79:0]        alu_a;
   logic [79:0]        alu_b;
   logic               alu_sub;
   logic [80:0]        alu_y;
   logic               alu_ge;
   logic [79:0]        acc_mul;
   logic [33:0]        div_rem_sh;
   logic [33:0]        sq_rem_sh;
   logic [33:0]        sq_trial;
   logic [33:0]        rem_div;
   logic [33:0]        rem_sq;
   logic [79:0]        opa_div;
   logic [27:0]        root_sq;
   logic               phase_end;
   logic signed [31:0] mean_val;
   logic signed [39:0] mean_wide;
   logic signed [39:0] zd_wide;
   logic signed [39:0] band_lo_raw;
   logic signed [39:0] band_hi_raw;
   logic signed [39:0] band_lo;
   logic signed [39:0] band_hi;
   logic signed [39:0] min_q8;
   logic signed [39:0] max_q8;

   // Sample sign extension and magnitudes.
   assign smp      = 24'(signed'(req_if.sample[sse_pkg::SampleBits-1:0]));
   assign smp_mag  = smp[23] ? 24'(-smp) : 24'(smp);
   assign sum_mag  = sum_ff[39] ? 40'(-sum_ff) : 40'(sum_ff);
   assign req_xfer = req_if.valid && req_if.ready;
   assign phase_end = (itr_ff == 7'd0);

   // Shared add/subtract unit; the carry out is the compare result.
   assign alu_y   = {1'b0, alu_a} + {1'b0, alu_b ^ {80{alu_sub}}} + 81'(alu_sub);
   assign alu_ge  = alu_y[80];
   assign acc_mul = opb_ff[0] ? alu_y[79:0] : acc_ff;

   // Restoring division step: next dividend bit into the remainder.
   assign div_rem_sh = {rem_ff[32:0], opa_ff[79]};
   assign rem_div    = alu_ge ? alu_y[33:0] : div_rem_sh;
   assign opa_div    = {opa_ff[78:0], alu_ge};

   // Square root step: two radicand bits in, one root bit out.
   assign sq_rem_sh = {rem_ff[31:0], opa_ff[79:78]};
   assign sq_trial  = {4'b0, root_ff, 2'b01};
   assign rem_sq    = alu_ge ? alu_y[33:0] : sq_rem_sh;
   assign root_sq   = {root_ff[26:0], alu_ge};

   // Band limits, widened and signed so that the arithmetic cannot wrap.
   assign min_q8      = 40'(min_ff) <<< 4;
   assign max_q8      = 40'(max_ff) <<< 4;
   assign mean_wide   = 40'(mean_ff);
   assign zd_wide     = signed'(40'(zd_ff));
   assign band_lo_raw = mean_wide - zd_wide;
   assign band_hi_raw = mean_wide + zd_wide;
   assign band_lo     = (band_lo_raw < min_q8) ? min_q8 : band_lo_raw;
   assign band_hi     = (band_hi_raw > max_q8) ? max_q8 : band_hi_raw;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sse_pkg::ST_IDLE:  if (req_xfer) state_in = sse_pkg::ST_SQR;
         sse_pkg::ST_SQR:   state_in = last_ff ? sse_pkg::ST_MNN : sse_pkg::ST_IDLE;
         sse_pkg::ST_MNN:   if (phase_end) state_in = sse_pkg::ST_MNS;
         sse_pkg::ST_MNS:   if (phase_end) state_in = sse_pkg::ST_MSS;
         sse_pkg::ST_MSS:   if (phase_end) state_in = sse_pkg::ST_DVAR;
         sse_pkg::ST_DVAR:  if (phase_end) state_in = sse_pkg::ST_QSD;
         sse_pkg::ST_QSD:   if (phase_end) state_in = sse_pkg::ST_DSE;
         sse_pkg::ST_DSE:   if (phase_end) state_in = sse_pkg::ST_QSE;
         sse_pkg::ST_QSE:   if (phase_end) state_in = sse_pkg::ST_MZ;
         sse_pkg::ST_MZ:    if (phase_end) state_in = sse_pkg::ST_DMEAN;
         sse_pkg::ST_DMEAN: if (phase_end) state_in = sse_pkg::ST_FIN;
         sse_pkg::ST_FIN:   if (fin_load) state_in = sse_pkg::ST_IDLE;
         default:           state_in = sse_pkg::ST_IDLE;
      endcase
   end

   // Handshakes and shared unit operand selection.
   always_comb begin
      req_if.ready = (state_ff == sse_pkg::ST_IDLE);
      csr_if.ready = 1'b1;
      fin_load     = (state_ff == sse_pkg::ST_FIN) && (!rsp_valid_ff || rsp_if.ready);
      alu_a        = acc_ff;
      alu_b        = opa_ff;
      alu_sub      = 1'b0;
      unique case (state_ff)
         sse_pkg::ST_MSS: begin
            alu_sub = 1'b1;
         end
         sse_pkg::ST_DVAR: begin
            alu_a   = 80'(div_rem_sh);
            alu_b   = 80'(dsr_ff);
            alu_sub = 1'b1;
         end
         sse_pkg::ST_DSE, sse_pkg::ST_DMEAN: begin
            alu_a   = 80'(div_rem_sh);
            alu_b   = 80'(nsmp_ff);
            alu_sub = 1'b1;
         end
         sse_pkg::ST_QSD, sse_pkg::ST_QSE: begin
            alu_a   = 80'(sq_rem_sh);
            alu_b   = 80'(sq_trial);
            alu_sub = 1'b1;
         end
         default: begin
            alu_sub = 1'b0;
         end
      endcase
   end

   // Signed mean from the magnitude quotient of the last division.
   assign mean_val = sum_ff[39] ? 32'(-opa_div[43:0]) : 32'(opa_div[43:0]);

   // Control state and accumulators.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sse_pkg::ST_IDLE;
         z_ff         <= sse_pkg::ZFactorReset;
         nsmp_ff      <= '0;
         min_ff       <= 24'sh7FFFFF;
         max_ff       <= 24'sh800000;
         sum_ff       <= '0;
         ssum_ff      <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_if.valid) begin
            z_ff <= csr_if.data;
         end
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_xfer) begin
            if (nsmp_ff < 17'(sse_pkg::MaxSamples)) begin
               nsmp_ff <= nsmp_ff + 17'd1;
               if (smp < min_ff) min_ff <= smp;
               if (smp > max_ff) max_ff <= smp;
               sum_ff <= sum_ff + 40'(smp);
            end else begin
               drop_ff <= 1'b1;
            end
         end
         if (state_ff == sse_pkg::ST_SQR) begin
            ssum_ff <= ssum_ff + 63'(48'(mag_ff) * 48'(mag_ff));
         end
         // Result loaded: the set's accumulators return to their reset values.
         if (fin_load) begin
            nsmp_ff      <= '0;
            min_ff       <= 24'sh7FFFFF;
            max_ff       <= 24'sh800000;
            sum_ff       <= '0;
            ssum_ff      <= '0;
            drop_ff      <= 1'b0;
         end
      end
   end

   // Shared unit datapath; each phase before the mean division loads the operands of the next one.
   always_ff @(posedge clock) begin
      case (state_ff)
         sse_pkg::ST_IDLE: begin
            if (req_xfer) begin
               mag_ff  <= (nsmp_ff < 17'(sse_pkg::MaxSamples)) ? smp_mag : '0;
               last_ff <= req_if.last;
            end
         end
         sse_pkg::ST_SQR: begin
            acc_ff <= '0;
            opa_ff <= 80'(nsmp_ff);
            opb_ff <= 64'(nsmp_ff);
            itr_ff <= 7'd16;
         end
         sse_pkg::ST_MNN, sse_pkg::ST_MNS, sse_pkg::ST_MSS, sse_pkg::ST_MZ: begin
            if (!phase_end) begin
               acc_ff <= acc_mul;
               opa_ff <= {opa_ff[78:0], 1'b0};
               opb_ff <= {1'b0, opb_ff[63:1]};
               itr_ff <= itr_ff - 7'd1;
            end else begin
               case (state_ff)
                  sse_pkg::ST_MNN: begin
                     dsr_ff <= acc_mul[32:0];
                     acc_ff <= '0;
                     opa_ff <= 80'(ssum_ff);
                     opb_ff <= 64'(nsmp_ff);
                     itr_ff <= 7'd16;
                  end
                  sse_pkg::ST_MNS: begin
                     acc_ff <= acc_mul;
                     opa_ff <= 80'(sum_mag);
                     opb_ff <= 64'(sum_mag);
                     itr_ff <= 7'd39;
                  end
                  sse_pkg::ST_MSS: begin
                     opa_ff <= acc_mul;
                     rem_ff <= '0;
                     itr_ff <= 7'd79;
                  end
                  default: begin
                     zd_ff  <= acc_mul[43:8];
                     opa_ff <= {sum_mag, 40'b0};
                     rem_ff <= '0;
                     itr_ff <= 7'd43;
                  end
               endcase
            end
         end
         sse_pkg::ST_DVAR, sse_pkg::ST_DSE, sse_pkg::ST_DMEAN: begin
            if (phase_end && state_ff == sse_pkg::ST_DVAR) begin
               var_ff  <= opa_div[46:0];
               opa_ff  <= {1'b0, opa_div[46:0], 32'b0};
               rem_ff  <= '0;
               root_ff <= '0;
               itr_ff  <= 7'd27;
            end else if (phase_end && state_ff == sse_pkg::ST_DSE) begin
               opa_ff  <= {1'b0, opa_div[54:0], 24'b0};
               rem_ff  <= '0;
               root_ff <= '0;
               itr_ff  <= 7'd27;
            end else begin
               rem_ff <= rem_div;
               opa_ff <= opa_div;
               itr_ff <= itr_ff - 7'd1;
               // The mean is kept here until the result is loaded.
               if (phase_end) begin
                  mean_ff <= mean_val;
               end
            end
         end
         sse_pkg::ST_QSD, sse_pkg::ST_QSE: begin
            if (phase_end && state_ff == sse_pkg::ST_QSD) begin
               sd_ff  <= root_sq;
               opa_ff <= {var_ff, 33'b0};
               rem_ff <= '0;
               itr_ff <= 7'd54;
            end else if (phase_end && state_ff == sse_pkg::ST_QSE) begin
               se_ff  <= root_sq;
               acc_ff <= '0;
               opa_ff <= 80'(sd_ff);
               opb_ff <= 64'(z_ff);
               itr_ff <= 7'd15;
            end else begin
               rem_ff  <= rem_sq;
               root_ff <= root_sq;
               opa_ff  <= {opa_ff[77:0], 2'b0};
               itr_ff  <= itr_ff - 7'd1;
            end
         end
         default: begin
            itr_ff <= itr_ff;
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (fin_load) begin
         rsp_if.count      <= nsmp_ff;
         rsp_if.total      <= sum_ff;
         rsp_if.mean       <= mean_ff;
         rsp_if.minimum    <= min_ff;
         rsp_if.maximum    <= max_ff;
         rsp_if.variance   <= var_ff;
         rsp_if.std_dev    <= sd_ff;
         rsp_if.std_err    <= se_ff;
         rsp_if.band_low   <= 32'(band_lo);
         rsp_if.band_high  <= 32'(band_hi);
         rsp_if.overflowed <= drop_ff;
      end
   end

   // The result is offered until its transfer completes.
   assign rsp_if.valid = rsp_valid_ff;

   // The sample count never passes capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      nsmp_ff <= 17'(sse_pkg::MaxSamples))
      else $error("sample count above capacity");

   // Loading a result clears the accumulators for the next set.
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      fin_load |=> (nsmp_ff == 17'd0 || $past(req_xfer) == 1'b0) && ssum_ff == '0)
      else $error("accumulators not cleared after result");

   // A given result always covers at least one sample.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_if.count != 17'd0)
      else $error("result with empty count");

   // The standard deviation never exceeds the root of the scaled variance.
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 56'(rsp_if.std_dev) * 56'(rsp_if.std_dev)
                       <= {1'b0, rsp_if.variance, 8'b0})
      else $error("standard deviation above root of variance");

   // The band never inverts.
   a_band_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_if.band_low <= rsp_if.band_high)
      else $error("band low above band high");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the summary statistics engine: data sets of Q20.4
// samples are compared, result by result, against a predictor of the statistics.
// Depends on sse_pkg, the channels in sse_channels.sv and the engine top level.
`timescale 1ns / 100ps

module testbench;

   // Cycles without any transfer before the run is abandoned.
   localparam int StallLimit = 20000;
   // Closing latency of one data set, with margin.
   localparam int SettleCycles = 400;

   typedef struct {
      logic signed [23:0] sample;
      logic               last;
   } sample_item_t;

   typedef struct {
      logic [16:0]        count;
      logic signed [39:0] total;
      logic signed [31:0] mean;
      logic signed [23:0] minimum;
      logic signed [23:0] maximum;
      logic [46:0]        variance;
      logic [27:0]        std_dev;
      logic [27:0]        std_err;
      logic signed [31:0] band_low;
      logic signed [31:0] band_high;
      logic               overflowed;
   } stats_t;

   logic clock;
   logic reset;

   sse_req_if req_ch ();
   sse_rsp_if rsp_ch ();
   sse_csr_if csr_ch ();

   summary_statistics_engine DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   sample_item_t pending_samples[$];
   stats_t       expected_stats[$];
   sample_item_t in_flight;

   int send_idle_pct;
   int recv_stall_pct;
   bit hold_sender;
   int error_count;
   int sets_checked;
   int samples_sent;
   int quiet_cycles;

   // Predictor copy of the engine's accumulators and register.
   logic [15:0]        z_gain;
   longint unsigned    acc_count;
   longint             acc_min;
   longint             acc_max;
   longint             acc_sum;
   longint unsigned    acc_squares;
   bit                 acc_dropped;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned floor_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned bit_pos;
      root = 0;
      bit_pos = 64'h4000_0000_0000_0000;
      while (bit_pos > x) bit_pos >>= 2;
      while (bit_pos != 0) begin
         if (x >= root + bit_pos) begin
            x -= root + bit_pos;
            root = (root >> 1) + bit_pos;
         end else begin
            root >>= 1;
         end
         bit_pos >>= 2;
      end
      return root;
   endfunction

   task automatic clear_accumulators();
      acc_count = 0;
      acc_min = 64'sd8388607;
      acc_max = -64'sd8388608;
      acc_sum = 0;
      acc_squares = 0;
      acc_dropped = 1'b0;
   endtask

   // Adds one accepted sample and, on last, queues the statistics of the set.
   task automatic accumulate_sample(sample_item_t item);
      longint          s;
      longint          mean;
      longint          lo_band;
      longint          hi_band;
      longint unsigned magnitude;
      longint unsigned var_q8;
      longint unsigned dev;
      longint unsigned err;
      longint unsigned zd;
      bit [127:0]      spread;
      stats_t          res;
      s = longint'(item.sample);
      if (acc_count < longint'(sse_pkg::MaxSamples)) begin
         magnitude = (s < 0) ? -s : s;
         acc_count++;
         if (s < acc_min) acc_min = s;
         if (s > acc_max) acc_max = s;
         acc_sum += s;
         acc_squares += magnitude * magnitude;
      end else begin
         acc_dropped = 1'b1;
      end
      if (!item.last) return;
      // The count is never zero here: a closing sample counts or capacity is full.
      mean = (acc_sum * 16) / longint'(acc_count);
      magnitude = (acc_sum < 0) ? -acc_sum : acc_sum;
      spread = 128'(acc_count) * 128'(acc_squares) - 128'(magnitude) * 128'(magnitude);
      var_q8 = 64'(spread / (128'(acc_count) * 128'(acc_count))) & ((64'd1 << 47) - 1);
      dev = floor_sqrt(var_q8 << 8);
      err = floor_sqrt((var_q8 << 8) / acc_count);
      zd = (64'(z_gain) * dev) >> 8;
      lo_band = mean - longint'(zd);
      hi_band = mean + longint'(zd);
      if (lo_band < acc_min * 16) lo_band = acc_min * 16;
      if (hi_band > acc_max * 16) hi_band = acc_max * 16;
      res.count = acc_count[16:0];
      res.total = acc_sum[39:0];
      res.mean = mean[31:0];
      res.minimum = acc_min[23:0];
      res.maximum = acc_max[23:0];
      res.variance = var_q8[46:0];
      res.std_dev = dev[27:0];
      res.std_err = err[27:0];
      res.band_low = lo_band[31:0];
      res.band_high = hi_band[31:0];
      res.overflowed = acc_dropped;
      expected_stats = {expected_stats, res};
      clear_accumulators();
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Driver: presents queued samples, idling at the current rate.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            accumulate_sample(in_flight);
            samples_sent++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_samples.size() > 0 && !hold_sender &&
                $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_samples.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.sample <= in_flight.sample;
               req_ch.last <= in_flight.last;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stalls at the current rate and checks each result transfer.
   always @(posedge clock) begin
      stats_t want;
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: result transfer with no data set closed", $time);
            error_count++;
         end else begin
            want = expected_stats.pop_front();
            check_field("count", 64'(want.count), 64'(rsp_ch.count));
            check_field("total", 64'(want.total), 64'(rsp_ch.total));
            check_field("mean", 64'(want.mean), 64'(rsp_ch.mean));
            check_field("minimum", 64'(want.minimum), 64'(rsp_ch.minimum));
            check_field("maximum", 64'(want.maximum), 64'(rsp_ch.maximum));
            check_field("variance", 64'(want.variance), 64'(rsp_ch.variance));
            check_field("std_dev", 64'(want.std_dev), 64'(rsp_ch.std_dev));
            check_field("std_err", 64'(want.std_err), 64'(rsp_ch.std_err));
            check_field("band_low", 64'(want.band_low), 64'(rsp_ch.band_low));
            check_field("band_high", 64'(want.band_high), 64'(rsp_ch.band_high));
            check_field("overflowed", 64'(want.overflowed), 64'(rsp_ch.overflowed));
            sets_checked++;
         end
      end
   end

   // Watchdog: any transfer on the sample or result channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("summary_statistics_engine: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_sample(logic signed [23:0] value, logic closes);
      sample_item_t item;
      item.sample = value;
      item.last = closes;
      pending_samples = {pending_samples, item};
   endtask

   // Waits until every sample is taken and every result checked, then settles.
   task automatic wait_drained();
      while (pending_samples.size() > 0 || req_ch.valid || expected_stats.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_z_factor(logic [15:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      z_gain = value;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic signed [23:0] random_sample();
      case ($urandom_range(5))
         0: return 24'sh7FFFFF;
         1: return -24'sh800000;
         2: return 24'($signed($urandom_range(64)) - 32);
         3: return 24'($urandom_range(4095));
         default: return 24'($urandom);
      endcase
   endfunction

   // One random data set of mostly short length; a few are longer.
   task automatic push_random_set();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len; i++) push_sample(random_sample(), i == len - 1);
   endtask

   initial begin
      logic [15:0] z_values[4];
      int          idle_rates[4];
      int          stall_rates[4];
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.sample = '0;
      req_ch.last = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.data = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_sender = 1'b0;
      error_count = 0;
      sets_checked = 0;
      samples_sent = 0;
      z_gain = sse_pkg::ZFactorReset;
      clear_accumulators();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sets at the reset z factor: single samples, extremes, sign cases.
      push_sample(24'sd0, 1'b1);
      push_sample(24'sh7FFFFF, 1'b1);
      push_sample(-24'sh800000, 1'b1);
      push_sample(24'sh7FFFFF, 1'b0);
      push_sample(-24'sh800000, 1'b1);
      push_sample(-24'sh800000, 1'b0);
      push_sample(-24'sh800000, 1'b0);
      push_sample(-24'sh800000, 1'b1);
      push_sample(-24'sd1, 1'b0);
      push_sample(24'sd2, 1'b0);
      push_sample(-24'sd3, 1'b1);
      push_sample(24'sd5, 1'b0);
      push_sample(24'sd5, 1'b0);
      push_sample(24'sd6, 1'b1);
      wait_drained();

      z_values = '{16'hFFFF, 16'h0000, 16'($urandom), sse_pkg::ZFactorReset};
      idle_rates = '{0, 78, 0, 6};
      stall_rates = '{0, 0, 78, 6};
      for (int phase = 0; phase < 4; phase++) begin
         write_z_factor(z_values[phase]);
         send_idle_pct = idle_rates[phase];
         recv_stall_pct = stall_rates[phase];
         for (int k = 0; k < 32; k++) begin
            push_random_set();
            // Halfway through, the sender waits for every result so far in the phase.
            if (k == 16) begin
               while (pending_samples.size() > 0 || req_ch.valid) @(posedge clock);
               hold_sender = 1'b1;
               while (expected_stats.size() > 0) @(posedge clock);
               hold_sender = 1'b0;
            end
         end
         wait_drained();
      end

      $display("Checked %0d data sets from %0d samples, extremes and sign cases included,",
               sets_checked, samples_sent);
      $display("over four z factor settings and four idle and stall patterns.");
      if (error_count == 0) begin
         $display("summary_statistics_engine: match");
      end else begin
         $display("summary_statistics_engine: mismatch");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/sse_pkg.sv
hdl/sse_channels.sv
hdl/summary_statistics_engine.sv
tb/testbench.sv
